// ===== design/kpdq_pkg.sv =====
// Shared types and constants of the key-frame preserving drop queue.
`timescale 1ns / 1ps

package kpdq_pkg;

    // Fixed field widths
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 24;
    localparam int LIMIT_W  = 5;
    localparam int FILL_W   = 5;
    localparam int CNT_W    = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Item command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Input item
    typedef struct packed {
        logic                cmd;
        logic [HANDLE_W-1:0] frame_handle;
        logic [LEN_W-1:0]    frame_length;
        logic                is_key;
    } t_kpdq_in;

    // Result item
    typedef struct packed {
        logic                pop_valid;
        logic [HANDLE_W-1:0] pop_handle;
        logic [LEN_W-1:0]    pop_length;
        logic                pop_key;
        logic                drop_done;
        logic [HANDLE_W-1:0] drop_handle;
        logic [FILL_W-1:0]   fill_level;
        logic [CNT_W-1:0]    drops_total;
        logic [CNT_W-1:0]    pops_total;
    } t_kpdq_out;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_POP,
        OP_PUSH,
        OP_START_DROP,
        OP_SCAN,
        OP_FINISH
    } t_kpdq_op;

    // Datapath status seen by the controller
    typedef struct packed {
        logic need_drop;
        logic scan_last;
    } t_kpdq_stat;

endpackage

// ===== design/kpdq_ctrl.sv =====
// Controller state machine of the key-frame preserving drop queue.
`timescale 1ns / 1ps

module kpdq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_cmd,
    input  kpdq_pkg::t_kpdq_stat i_stat,
    output kpdq_pkg::t_kpdq_op  o_op,
    output logic                o_busy
);
    import kpdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Next state and datapath operation
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_POP) begin
                        o_op = OP_POP;
                    end else if (i_stat.need_drop) begin
                        o_op    = OP_START_DROP;
                        n_state = S_SCAN;
                    end else begin
                        o_op = OP_PUSH;
                    end
                end
            end
            S_SCAN: begin
                o_op = OP_SCAN;
                if (i_stat.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_op    = OP_FINISH;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== design/kpdq_dp.sv =====
// Datapath of the key-frame preserving drop queue: shift cells, counters, result register.
`timescale 1ns / 1ps

module kpdq_dp #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kpdq_pkg::t_kpdq_op                  i_op,
    input  kpdq_pkg::t_kpdq_in                  i_item,
    input  logic                                i_cfg_we,
    input  logic [kpdq_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    output kpdq_pkg::t_kpdq_stat                o_stat,
    output logic                                o_strobe,
    output kpdq_pkg::t_kpdq_out                 o_result
);
    import kpdq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int LW    = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

    // Queue cells, head at index 0
    logic [HANDLE_BITS-1:0] r_hnd  [DEPTH];
    logic [LEN_W-1:0]       r_len  [DEPTH];
    logic                   r_key  [DEPTH];
    logic [HANDLE_BITS-1:0] n_hnd  [DEPTH];
    logic [LEN_W-1:0]       n_len  [DEPTH];
    logic                   n_key  [DEPTH];
    logic [HANDLE_BITS-1:0] up_hnd [DEPTH];
    logic [LEN_W-1:0]       up_len [DEPTH];
    logic                   up_key [DEPTH];

    // Control state
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [OCC_W-1:0]   r_left, n_left;
    logic               r_found, n_found;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [CNT_W-1:0]   r_drops, n_drops;
    logic [CNT_W-1:0]   r_pops, n_pops;
    logic               r_strobe, n_strobe;

    // Payload state
    logic [HANDLE_BITS-1:0] r_in_hnd, n_in_hnd;
    logic [LEN_W-1:0]       r_in_len, n_in_len;
    logic                   r_in_key, n_in_key;
    logic [HANDLE_BITS-1:0] r_drop_h, n_drop_h;
    t_kpdq_out              r_res, n_res;

    logic [OCC_W-1:0]       occ_m1;
    logic                   occ_nz;
    logic                   scan_drop;
    logic [HANDLE_BITS-1:0] item_hnd;
    logic [LW-1:0]          lim_raw;
    logic [LW-1:0]          lim_eff;

    assign occ_m1    = r_occ - 1'b1;
    assign occ_nz    = (r_occ != '0);
    assign scan_drop = !r_found && !r_key[0];
    assign item_hnd  = HANDLE_BITS'(i_item.frame_handle);

    // Effective limit clamped to 1..DEPTH
    assign lim_raw = (r_limit == '0) ? LW'(1) : LW'(r_limit);
    assign lim_eff = (lim_raw > LW'(DEPTH)) ? LW'(DEPTH) : lim_raw;

    assign o_stat.need_drop = occ_nz && (LW'(r_occ) >= lim_eff);
    assign o_stat.scan_last = (r_left == OCC_W'(1));

    // Per-cell next value: hold, shift up, take new item or take the rotated head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [OCC_W-1:0] POS = OCC_W'(g);

        if (g < DEPTH - 1) begin : g_up
            assign up_hnd[g] = r_hnd[g+1];
            assign up_len[g] = r_len[g+1];
            assign up_key[g] = r_key[g+1];
        end else begin : g_last
            assign up_hnd[g] = r_hnd[g];
            assign up_len[g] = r_len[g];
            assign up_key[g] = r_key[g];
        end

        always_comb begin
            n_hnd[g] = r_hnd[g];
            n_len[g] = r_len[g];
            n_key[g] = r_key[g];
            unique case (i_op)
                OP_POP: begin
                    if (occ_nz) begin
                        n_hnd[g] = up_hnd[g];
                        n_len[g] = up_len[g];
                        n_key[g] = up_key[g];
                    end
                end
                OP_PUSH: begin
                    if (r_occ == POS) begin
                        n_hnd[g] = item_hnd;
                        n_len[g] = i_item.frame_length;
                        n_key[g] = i_item.is_key;
                    end
                end
                OP_SCAN: begin
                    // rotate the head to the tail, or remove it if it is the victim
                    if (!scan_drop && occ_m1 == POS) begin
                        n_hnd[g] = r_hnd[0];
                        n_len[g] = r_len[0];
                        n_key[g] = r_key[0];
                    end else begin
                        n_hnd[g] = up_hnd[g];
                        n_len[g] = up_len[g];
                        n_key[g] = up_key[g];
                    end
                end
                OP_FINISH: begin
                    if (r_found) begin
                        if (r_occ == POS) begin
                            n_hnd[g] = r_in_hnd;
                            n_len[g] = r_in_len;
                            n_key[g] = r_in_key;
                        end
                    end else if (occ_m1 == POS) begin
                        // all key frames: head dropped, new item at the tail
                        n_hnd[g] = r_in_hnd;
                        n_len[g] = r_in_len;
                        n_key[g] = r_in_key;
                    end else begin
                        n_hnd[g] = up_hnd[g];
                        n_len[g] = up_len[g];
                        n_key[g] = up_key[g];
                    end
                end
                default: begin
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_hnd[g] <= n_hnd[g];
            r_len[g] <= n_len[g];
            r_key[g] <= n_key[g];
        end
    end

    // Occupancy, scan state, counters and result
    always_comb begin
        n_occ    = r_occ;
        n_left   = r_left;
        n_found  = r_found;
        n_drops  = r_drops;
        n_pops   = r_pops;
        n_strobe = 1'b0;
        n_in_hnd = r_in_hnd;
        n_in_len = r_in_len;
        n_in_key = r_in_key;
        n_drop_h = r_drop_h;
        n_res    = r_res;
        n_limit  = i_cfg_we ? i_cfg_wdata : r_limit;
        unique case (i_op)
            OP_POP: begin
                n_strobe = 1'b1;
                n_res    = '0;
                if (occ_nz) begin
                    n_res.pop_valid  = 1'b1;
                    n_res.pop_handle = HANDLE_W'(r_hnd[0]);
                    n_res.pop_length = r_len[0];
                    n_res.pop_key    = r_key[0];
                    n_occ            = occ_m1;
                    n_pops           = r_pops + 1'b1;
                end
            end
            OP_PUSH: begin
                n_strobe = 1'b1;
                n_res    = '0;
                n_occ    = r_occ + 1'b1;
            end
            OP_START_DROP: begin
                n_in_hnd = item_hnd;
                n_in_len = i_item.frame_length;
                n_in_key = i_item.is_key;
                n_left   = r_occ;
                n_found  = 1'b0;
            end
            OP_SCAN: begin
                n_left = r_left - 1'b1;
                if (scan_drop) begin
                    n_found  = 1'b1;
                    n_drop_h = r_hnd[0];
                    n_occ    = occ_m1;
                end
            end
            OP_FINISH: begin
                n_strobe          = 1'b1;
                n_res             = '0;
                n_res.drop_done   = 1'b1;
                n_res.drop_handle = HANDLE_W'(r_found ? r_drop_h : r_hnd[0]);
                n_drops           = r_drops + 1'b1;
                if (r_found) begin
                    n_occ = r_occ + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (n_strobe) begin
            n_res.fill_level  = FILL_W'(n_occ);
            n_res.drops_total = n_drops;
            n_res.pops_total  = n_pops;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_left   <= '0;
            r_found  <= 1'b0;
            r_limit  <= LIMIT_RESET;
            r_drops  <= '0;
            r_pops   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            r_left   <= n_left;
            r_found  <= n_found;
            r_limit  <= n_limit;
            r_drops  <= n_drops;
            r_pops   <= n_pops;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in_hnd <= n_in_hnd;
        r_in_len <= n_in_len;
        r_in_key <= n_in_key;
        r_drop_h <= n_drop_h;
        r_res    <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// ===== design/keyframe_preserving_drop_queue_core.sv =====
// Top level of the key-frame preserving drop queue.
`timescale 1ns / 1ps

// Bounded queue of frame descriptors that, when full, drops the oldest
// non-key entry (or the head if all entries are key frames).
// Command channel: an item is taken on a rising edge with start high and
// busy low; i_item.cmd selects push or pop. Every item gives one result on
// o_result, marked by o_strobe for exactly one cycle; the receiver cannot
// stall it, and the next item may be taken while a result is shown.
// Pops and pushes that need no drop: result in the cycle after acceptance,
// busy stays low, one item per cycle.
// Push that forces a drop: the controller rotates the held entries through
// the head cell one per cycle to find the victim, then stores the new item;
// busy stays high while every held entry is rotated and the new item is stored, and the result follows.
// The limit register is written via i_cfg_we / i_cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce it. Values of 0 act as
// 1 and values above DEPTH act as DEPTH. Reset empties the queue, clears both
// counters and sets the limit to 16; no clearing pass is needed.

module keyframe_preserving_drop_queue_core #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  kpdq_pkg::t_kpdq_in           i_item,
    output logic                         busy,
    output logic                         o_strobe,
    output kpdq_pkg::t_kpdq_out          o_result,
    input  logic                         i_cfg_we,
    input  logic [kpdq_pkg::LIMIT_W-1:0] i_cfg_wdata
);
    import kpdq_pkg::*;

    t_kpdq_op   op;
    t_kpdq_stat stat;

    // Sequencer
    kpdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy)
    );

    // Cells, counters and result register
    kpdq_dp #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// ===== test/keyframe_preserving_drop_queue_core_tb.sv =====
// Self-checking testbench for the key-frame preserving drop queue core.
`timescale 1ns / 1ps

module keyframe_preserving_drop_queue_core_tb;

    import kpdq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int HANDLE_BITS  = 32;
    localparam int SETTLE       = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 200;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind         kind;
        t_kpdq_in           item;
        logic [LIMIT_W-1:0] limit;
        int unsigned        idle_pct;
    } t_step;

    // DUT ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    t_kpdq_in           i_item      = '0;
    logic               busy;
    logic               o_strobe;
    t_kpdq_out          o_result;
    logic               i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = LIMIT_RESET;

    // Stimulus backlog and results still owed by the block
    t_step     cmd_backlog[$];
    t_kpdq_out awaited_results[$];

    // Mirror of the queue contents, counters and limit
    logic [HANDLE_W-1:0] mirror_handle[DEPTH];
    logic [LEN_W-1:0]    mirror_length[DEPTH];
    logic                mirror_key[DEPTH];
    int unsigned         mirror_fill   = 0;
    logic [CNT_W-1:0]    mirror_drops  = '0;
    logic [CNT_W-1:0]    mirror_pops   = '0;
    logic [LIMIT_W-1:0]  mirror_limit  = LIMIT_RESET;

    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_cycles = 0;

    keyframe_preserving_drop_queue_core #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Take one entry out of the mirror and close the gap behind it
    task automatic remove_slot(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < mirror_fill; i++) begin
            mirror_handle[i] = mirror_handle[i + 1];
            mirror_length[i] = mirror_length[i + 1];
            mirror_key[i]    = mirror_key[i + 1];
        end
        if (mirror_fill > 0)
            mirror_fill--;
    endtask

    // Apply one accepted item to the mirror and queue the result it owes
    task automatic apply_to_mirror(input t_kpdq_in it);
        t_kpdq_out   res;
        int unsigned lim;
        int unsigned victim;
        bit          found;
        res = '0;
        lim = 32'(mirror_limit);
        if (lim < 1)
            lim = 1;
        if (lim > DEPTH)
            lim = DEPTH;
        if (it.cmd == CMD_PUSH) begin
            // full: evict the oldest non-key entry, else the head
            if (mirror_fill >= lim && mirror_fill > 0) begin
                victim = 0;
                found  = 1'b0;
                for (int unsigned i = 0; i < mirror_fill; i++) begin
                    if (!found && !mirror_key[i]) begin
                        victim = i;
                        found  = 1'b1;
                    end
                end
                res.drop_done   = 1'b1;
                res.drop_handle = mirror_handle[victim];
                remove_slot(victim);
                mirror_drops = mirror_drops + 1'b1;
            end
            if (mirror_fill < DEPTH) begin
                mirror_handle[mirror_fill] = it.frame_handle;
                mirror_length[mirror_fill] = it.frame_length;
                mirror_key[mirror_fill]    = it.is_key;
                mirror_fill++;
            end
        end else if (mirror_fill > 0) begin
            res.pop_valid  = 1'b1;
            res.pop_handle = mirror_handle[0];
            res.pop_length = mirror_length[0];
            res.pop_key    = mirror_key[0];
            remove_slot(0);
            mirror_pops = mirror_pops + 1'b1;
        end
        res.fill_level  = mirror_fill[FILL_W-1:0];
        res.drops_total = mirror_drops;
        res.pops_total  = mirror_pops;
        awaited_results.insert(awaited_results.size(), res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Backlog builders
    task automatic add_push(input logic [HANDLE_W-1:0] h, input logic [LEN_W-1:0] len,
                            input logic key, input int unsigned idle);
        t_step s;
        s.kind              = STEP_ITEM;
        s.item.cmd          = CMD_PUSH;
        s.item.frame_handle = h;
        s.item.frame_length = len;
        s.item.is_key       = key;
        s.limit             = '0;
        s.idle_pct          = idle;
        cmd_backlog.insert(cmd_backlog.size(), s);
    endtask

    task automatic add_pop(input int unsigned idle);
        t_step s;
        s.kind              = STEP_ITEM;
        s.item.cmd          = CMD_POP;
        s.item.frame_handle = $urandom;
        s.item.frame_length = LEN_W'($urandom_range(32'hFF_FFFF));
        s.item.is_key       = 1'($urandom_range(1));
        s.limit             = '0;
        s.idle_pct          = idle;
        cmd_backlog.insert(cmd_backlog.size(), s);
    endtask

    task automatic add_cfg(input logic [LIMIT_W-1:0] lim);
        t_step s;
        s.kind     = STEP_CFG;
        s.item     = '0;
        s.limit    = lim;
        s.idle_pct = 0;
        cmd_backlog.insert(cmd_backlog.size(), s);
    endtask

    task automatic add_drain();
        t_step s;
        s.kind     = STEP_DRAIN;
        s.item     = '0;
        s.limit    = '0;
        s.idle_pct = 0;
        cmd_backlog.insert(cmd_backlog.size(), s);
    endtask

    // Driver: issues items, limit writes and drain pauses from the backlog
    always @(posedge i_clk) begin : drive
        logic nxt_start;
        logic nxt_we;
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                apply_to_mirror(cmd_backlog[0].item);
                cmd_backlog.delete(0);
            end
            // nothing in flight: count towards the settle time
            if (awaited_results.size() == 0 && !start && !busy && !o_strobe)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (start && busy) begin
                nxt_start = 1'b1;
            end else if (cmd_backlog.size() > 0 && !i_cfg_we) begin
                case (cmd_backlog[0].kind)
                    STEP_ITEM: begin
                        if ($urandom_range(99) >= cmd_backlog[0].idle_pct) begin
                            nxt_start = 1'b1;
                            i_item <= cmd_backlog[0].item;
                        end
                    end
                    STEP_CFG: begin
                        if (quiet_cycles >= SETTLE) begin
                            nxt_we = 1'b1;
                            i_cfg_wdata  <= cmd_backlog[0].limit;
                            mirror_limit = cmd_backlog[0].limit;
                            cmd_backlog.delete(0);
                        end
                    end
                    default: begin
                        if (quiet_cycles >= SETTLE)
                            cmd_backlog.delete(0);
                    end
                endcase
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // Monitor: every strobed result against the oldest expectation
    always @(posedge i_clk) begin : watch_results
        t_kpdq_out want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                check_field("pop_valid",   32'(want.pop_valid),   32'(o_result.pop_valid));
                check_field("pop_handle",  32'(want.pop_handle),  32'(o_result.pop_handle));
                check_field("pop_length",  32'(want.pop_length),  32'(o_result.pop_length));
                check_field("pop_key",     32'(want.pop_key),     32'(o_result.pop_key));
                check_field("drop_done",   32'(want.drop_done),   32'(o_result.drop_done));
                check_field("drop_handle", 32'(want.drop_handle), 32'(o_result.drop_handle));
                check_field("fill_level",  32'(want.fill_level),  32'(o_result.fill_level));
                check_field("drops_total", 32'(want.drops_total), 32'(o_result.drops_total));
                check_field("pops_total",  32'(want.pops_total),  32'(o_result.pops_total));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [LIMIT_W-1:0]  phase_limit[PHASES];
        int unsigned         phase_idle[PHASES];
        int unsigned         phase_key[PHASES];
        int unsigned         phase_push[PHASES];
        logic [HANDLE_W-1:0] h;
        int unsigned         pick;
        phase_limit = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd0, 5'd16, 5'd2, 5'd17, 5'd7, 5'd16};
        phase_idle  = '{0, 85, 22, 0, 85, 22, 0, 85, 22, 0};
        phase_key   = '{20, 50, 0, 100, 30, 10, 100, 40, 25, 60};
        phase_push  = '{75, 65, 60, 70, 55, 80, 60, 50, 65, 55};

        // Directed: empty pops and field extremes at the reset limit
        add_pop(0);
        add_push('0, '0, 1'b0, 0);
        add_push('1, '1, 1'b1, 0);
        add_pop(0);
        add_pop(0);
        add_pop(0);
        // limit 2: non-key eviction behind a key head, then all-key head drop
        add_cfg(5'd2);
        add_push(32'hA0A0_0001, 24'h00_0100, 1'b1, 0);
        add_push(32'hB0B0_0002, 24'h00_0200, 1'b0, 0);
        add_push(32'hC0C0_0003, 24'h00_0300, 1'b0, 0);
        add_push(32'hD0D0_0004, 24'h00_0400, 1'b1, 0);
        add_push(32'hE0E0_0005, 24'h00_0500, 1'b1, 0);
        add_pop(0);
        add_pop(0);
        // limit zero behaves as one
        add_cfg(5'd0);
        add_push(32'h1234_5678, 24'h55_AA55, 1'b0, 0);
        add_push(32'h8765_4321, 24'hAA_55AA, 1'b0, 0);
        add_pop(0);

        // Random phases; lowering the limit after a full queue is covered
        // by the phase order
        for (int p = 0; p < PHASES; p++) begin
            add_cfg(phase_limit[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(99) == 0)
                    add_drain();
                if ($urandom_range(99) < phase_push[p]) begin
                    pick = $urandom_range(15);
                    h = (pick == 0) ? '0 : (pick == 1) ? '1 : HANDLE_W'($urandom);
                    add_push(h, (pick == 2) ? '1 : LEN_W'($urandom_range(32'hFF_FFFF)),
                             $urandom_range(99) < phase_key[p], phase_idle[p]);
                end else begin
                    add_pop(phase_idle[p]);
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/kpdq_pkg.sv
design/kpdq_ctrl.sv
design/kpdq_dp.sv
design/keyframe_preserving_drop_queue_core.sv
test/keyframe_preserving_drop_queue_core_tb.sv
